@@ rtl/cpft_pkg.sv @@
// Package for the clock page frame table: request, result and entry types,
// request codes and flag bit positions. No dependencies.
package cpft_pkg;

  localparam int OWNER_W = 18;
  localparam int PAGE_W  = 20;
  localparam int SLOT_W  = 10;
  localparam int FLAG_W  = 4;
  localparam int CFG_W   = 11;

  localparam logic [1:0] REQ_ACCESS  = 2'd0;
  localparam logic [1:0] REQ_DONE    = 2'd1;
  localparam logic [1:0] REQ_PIN     = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  localparam int FL_REF   = 0;
  localparam int FL_DIRTY = 1;
  localparam int FL_BUSY  = 2;
  localparam int FL_PIN   = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page_number;
    logic               is_write;
    logic [SLOT_W-1:0]  slot;
  } cpft_req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  entry_index;
    logic               victim_valid;
    logic [OWNER_W-1:0] victim_owner;
    logic [PAGE_W-1:0]  victim_page;
    logic               victim_dirty;
    logic               fail;
  } cpft_res_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page;
    logic [FLAG_W-1:0]  flags;
  } cpft_entry_t;

  localparam int ENTRY_W = $bits(cpft_entry_t);

endpackage

@@ rtl/cpft_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cpft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/clock_page_frame_table.sv @@
// Clock (second-chance) page frame table, top level.
// Depends on cpft_pkg and cpft_ram.
//
//   channel   ports                         handshake
//   request   in_req                        start high while busy low
//   result    out_res                       out_strobe, one cycle
//   config    cfg_we, cfg_wdata             cfg_we, taken at once
//
// Every table step reads one entry and evaluates it in the next cycle on the single
// RAM read port. An access searches the entries in use for a hit, then sweeps them
// from the hand at most twice over; done and pin touch one slot, release scans every
// entry in use, and an access or release by owner 0 is answered without a table step.
// After reset a clearing pass zeroes every entry of the table with busy high.
// The result strobe is never held off; the next request may start while it shows.
module clock_page_frame_table #(
  parameter int ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  cpft_pkg::cpft_req_t        in_req,
  output logic                       out_strobe,
  output cpft_pkg::cpft_res_t        out_res,
  input  logic                       cfg_we,
  input  logic [cpft_pkg::CFG_W-1:0] cfg_wdata
);
  import cpft_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int NW = IW + 1;
  localparam int SW = IW + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_SRCH_RD = 4'd2;
  localparam logic [3:0] S_SRCH_EV = 4'd3;
  localparam logic [3:0] S_SWP_RD  = 4'd4;
  localparam logic [3:0] S_SWP_EV  = 4'd5;
  localparam logic [3:0] S_SLOT_RD = 4'd6;
  localparam logic [3:0] S_SLOT_EV = 4'd7;
  localparam logic [3:0] S_REL_RD  = 4'd8;
  localparam logic [3:0] S_REL_EV  = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic [IW-1:0]    hand_r, hand_nxt;
  cpft_req_t        req_r, req_nxt;
  cpft_res_t        res_r, res_nxt;
  logic             vld_r, vld_nxt;
  logic [CFG_W-1:0] cfg_r;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  cpft_entry_t      ram_wdata, ram_rdata;

  logic [NW-1:0]    n_used;
  logic [IW-1:0]    n_last, idx_wrap;
  logic [SW-1:0]    step_last;
  logic             own_match, evictable, passable;

  cpft_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (cfg_r == '0) begin
      n_used = NW'(1);
    end else if (32'(cfg_r) > ENTRIES) begin
      n_used = NW'(ENTRIES);
    end else begin
      n_used = NW'(cfg_r);
    end
  end

  assign n_last    = IW'(n_used - NW'(1));
  assign step_last = {1'b0, n_used} + {1'b0, n_used} - SW'(1);
  assign idx_wrap  = (idx_r == n_last) ? '0 : idx_r + IW'(1);
  assign own_match = (ram_rdata.owner == req_r.owner);
  // Pinned and busy entries are skipped unless empty; unreferenced or empty ones are taken.
  assign passable  = !ram_rdata.flags[FL_PIN] && !ram_rdata.flags[FL_BUSY];
  assign evictable = (ram_rdata.owner == '0) || (passable && !ram_rdata.flags[FL_REF]);

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = vld_r;
  assign out_res    = res_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    hand_nxt  = hand_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    vld_nxt   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          res_nxt = '0;
          idx_nxt = '0;
          case (in_req.req_type)
            REQ_ACCESS: begin
              if (in_req.owner == '0) begin
                res_nxt.fail = 1'b1;
                vld_nxt      = 1'b1;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            REQ_DONE, REQ_PIN: begin
              res_nxt.entry_index = in_req.slot;
              if (32'(in_req.slot) >= 32'(n_used)) begin
                res_nxt.fail = 1'b1;
                vld_nxt      = 1'b1;
              end else begin
                idx_nxt   = IW'(in_req.slot);
                state_nxt = S_SLOT_RD;
              end
            end
            default: begin
              if (in_req.owner == '0) begin
                vld_nxt = 1'b1;
              end else begin
                state_nxt = S_REL_RD;
              end
            end
          endcase
        end
      end

      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_nxt   = idx_r + IW'(1);
        if (32'(idx_r) == ENTRIES - 1) begin
          state_nxt = S_IDLE;
        end
      end

      S_SRCH_RD: state_nxt = S_SRCH_EV;

      S_SRCH_EV: begin
        if (ram_rdata.owner != '0 && own_match && ram_rdata.page == req_r.page_number) begin
          ram_we                    = 1'b1;
          ram_wdata.flags[FL_REF]   = 1'b1;
          ram_wdata.flags[FL_DIRTY] = ram_rdata.flags[FL_DIRTY] | req_r.is_write;
          res_nxt.hit               = 1'b1;
          res_nxt.entry_index       = SLOT_W'(idx_r);
          vld_nxt                   = 1'b1;
          state_nxt                 = S_IDLE;
        end else if (idx_r == n_last) begin
          idx_nxt   = (32'(hand_r) < 32'(n_used)) ? hand_r : '0;
          step_nxt  = '0;
          state_nxt = S_SWP_RD;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_SRCH_RD;
        end
      end

      S_SWP_RD: state_nxt = S_SWP_EV;

      S_SWP_EV: begin
        if (evictable) begin
          ram_we                    = 1'b1;
          ram_wdata.owner           = req_r.owner;
          ram_wdata.page            = req_r.page_number;
          ram_wdata.flags           = '0;
          ram_wdata.flags[FL_REF]   = 1'b1;
          ram_wdata.flags[FL_DIRTY] = req_r.is_write;
          res_nxt.entry_index       = SLOT_W'(idx_r);
          if (ram_rdata.owner != '0) begin
            res_nxt.victim_valid    = 1'b1;
            res_nxt.victim_owner    = ram_rdata.owner;
            res_nxt.victim_page     = ram_rdata.page;
            res_nxt.victim_dirty    = ram_rdata.flags[FL_DIRTY];
            ram_wdata.flags[FL_BUSY] = ram_rdata.flags[FL_DIRTY];
          end
          hand_nxt  = idx_wrap;
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (passable) begin
            ram_we                  = 1'b1;
            ram_wdata.flags[FL_REF] = 1'b0;
          end
          if (step_r == step_last) begin
            res_nxt.fail = 1'b1;
            vld_nxt      = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            step_nxt  = step_r + SW'(1);
            idx_nxt   = idx_wrap;
            state_nxt = S_SWP_RD;
          end
        end
      end

      S_SLOT_RD: state_nxt = S_SLOT_EV;

      S_SLOT_EV: begin
        ram_we = 1'b1;
        if (req_r.req_type == REQ_PIN) begin
          ram_wdata.owner         = req_r.owner;
          ram_wdata.page          = req_r.page_number;
          ram_wdata.flags         = '0;
          ram_wdata.flags[FL_PIN] = 1'b1;
        end else begin
          ram_wdata.flags[FL_BUSY] = 1'b0;
        end
        vld_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end

      S_REL_RD: state_nxt = S_REL_EV;

      S_REL_EV: begin
        if (own_match) begin
          ram_we    = 1'b1;
          ram_wdata = '0;
        end
        if (idx_r == n_last) begin
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_REL_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
      step_r  <= '0;
      hand_r  <= '0;
      vld_r   <= 1'b0;
      cfg_r   <= CFG_RESET;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      hand_r  <= hand_nxt;
      vld_r   <= vld_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

endmodule

@@ tb/clock_page_frame_table_tb.sv @@
// Self-checking testbench for clock_page_frame_table: a queue-fed driver, a result
// monitor and an in-bench table predictor across several table sizes.
// Depends on cpft_pkg and the clock_page_frame_table RTL.
module clock_page_frame_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpft_pkg::*;

  localparam int TBL = 1024;
  localparam int WATCHDOG = 60000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cpft_req_t in_req = '0;
  logic out_strobe;
  cpft_res_t out_res;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  clock_page_frame_table #(.ENTRIES(TBL)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted table state.
  logic [OWNER_W-1:0] tbl_owner [TBL];
  logic [PAGE_W-1:0]  tbl_page  [TBL];
  logic [FLAG_W-1:0]  tbl_flags [TBL];
  int unsigned        hand;
  logic [CFG_W-1:0]   size_reg;

  cpft_req_t pending_reqs[$];
  cpft_res_t expected_res[$];
  int  mismatches = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  quiet_cycles = 0;

  function automatic int unsigned active_entries();
    if (size_reg == 0) return 1;
    if (size_reg > TBL) return TBL;
    return size_reg;
  endfunction

  function automatic cpft_res_t table_lookup(cpft_req_t r);
    cpft_res_t res;
    int unsigned n, pos;
    logic [FLAG_W-1:0] f;
    bit found, dirty;
    res = '0;
    n = active_entries();
    case (r.req_type)
      REQ_ACCESS: begin
        if (r.owner == 0) begin
          res.fail = 1'b1;
          return res;
        end
        for (int i = 0; i < n; i++) begin
          if (tbl_owner[i] != 0 && tbl_owner[i] == r.owner && tbl_page[i] == r.page_number) begin
            tbl_flags[i][FL_REF] = 1'b1;
            if (r.is_write) tbl_flags[i][FL_DIRTY] = 1'b1;
            res.hit = 1'b1;
            res.entry_index = SLOT_W'(i);
            return res;
          end
        end
        pos = (hand < n) ? hand : 0;
        found = 1'b0;
        for (int s = 0; s < 2 * n; s++) begin
          f = tbl_flags[pos];
          if (tbl_owner[pos] == 0) begin
            found = 1'b1;
            break;
          end
          if (!f[FL_PIN] && !f[FL_BUSY]) begin
            if (!f[FL_REF]) begin
              found = 1'b1;
              break;
            end
            tbl_flags[pos][FL_REF] = 1'b0;
          end
          pos = (pos + 1 == n) ? 0 : pos + 1;
        end
        if (!found) begin
          res.fail = 1'b1;
          return res;
        end
        res.entry_index = SLOT_W'(pos);
        dirty = 1'b0;
        if (tbl_owner[pos] != 0) begin
          dirty = tbl_flags[pos][FL_DIRTY];
          res.victim_valid = 1'b1;
          res.victim_owner = tbl_owner[pos];
          res.victim_page = tbl_page[pos];
          res.victim_dirty = dirty;
        end
        tbl_owner[pos] = r.owner;
        tbl_page[pos] = r.page_number;
        tbl_flags[pos] = '0;
        tbl_flags[pos][FL_REF] = 1'b1;
        tbl_flags[pos][FL_DIRTY] = r.is_write;
        tbl_flags[pos][FL_BUSY] = dirty;
        hand = (pos + 1 == n) ? 0 : pos + 1;
      end
      REQ_DONE, REQ_PIN: begin
        res.entry_index = r.slot;
        if (r.slot >= n) begin
          res.fail = 1'b1;
        end else if (r.req_type == REQ_DONE) begin
          tbl_flags[r.slot][FL_BUSY] = 1'b0;
        end else begin
          tbl_owner[r.slot] = r.owner;
          tbl_page[r.slot] = r.page_number;
          tbl_flags[r.slot] = '0;
          tbl_flags[r.slot][FL_PIN] = 1'b1;
        end
      end
      default: begin
        if (r.owner != 0)
          for (int i = 0; i < n; i++)
            if (tbl_owner[i] == r.owner) begin
              tbl_owner[i] = '0;
              tbl_page[i] = '0;
              tbl_flags[i] = '0;
            end
      end
    endcase
    return res;
  endfunction

  // Driver: bursts of requests with random gaps, holding a request while busy.
  always @(posedge clk) begin
    if (start && !busy) begin
      expected_res.push_back(table_lookup(in_req));
    end
    if (!(start && busy)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_req <= pending_reqs.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    cpft_res_t want;
    if (out_strobe) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res);
      end else begin
        want = expected_res.pop_front();
        if (want.hit !== out_res.hit || want.entry_index !== out_res.entry_index ||
            want.victim_valid !== out_res.victim_valid ||
            want.victim_owner !== out_res.victim_owner ||
            want.victim_page !== out_res.victim_page ||
            want.victim_dirty !== out_res.victim_dirty || want.fail !== out_res.fail) begin
          mismatches++;
          if (mismatches <= 10) $display("result differs: expected %p got %p", want, out_res);
        end
      end
    end
    if (!(out_strobe || (start && !busy))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("clock_page_frame_table: mismatch");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  function automatic cpft_req_t make_req(logic [1:0] t, int o, int p, bit w, int s);
    cpft_req_t r;
    r.req_type = t;
    r.owner = OWNER_W'(o);
    r.page_number = PAGE_W'(p);
    r.is_write = w;
    r.slot = SLOT_W'(s);
    return r;
  endfunction

  function automatic cpft_req_t random_req();
    cpft_req_t r;
    int unsigned k, n;
    n = active_entries();
    k = $urandom_range(99, 0);
    r.req_type = (k < 62) ? REQ_ACCESS : (k < 80) ? REQ_DONE : (k < 90) ? REQ_PIN : REQ_RELEASE;
    k = $urandom_range(19, 0);
    r.owner = OWNER_W'((k == 0) ? 0 : (k == 1) ? $urandom_range(262143, 0) :
                       $urandom_range(5, 1));
    k = $urandom_range(19, 0);
    r.page_number = PAGE_W'((k == 0) ? $urandom_range(1048575, 0) : $urandom_range(9, 0));
    r.is_write = 1'($urandom_range(1, 0));
    r.slot = SLOT_W'(($urandom_range(9, 0) == 0) ? $urandom_range(1023, 0) :
                     $urandom_range(n + 1, 0));
    return r;
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || start || busy || expected_res.size() > 0);
  endtask

  task automatic set_entries(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    size_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [CFG_W-1:0] v, int count);
    set_entries(v);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // Let the table drain completely before continuing.
        drain();
      end
      pending_reqs.push_back(random_req());
    end
  endtask

  initial begin
    for (int i = 0; i < TBL; i++) begin
      tbl_owner[i] = '0;
      tbl_page[i] = '0;
      tbl_flags[i] = '0;
    end
    hand = 0;
    size_reg = CFG_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes on the full table.
    set_entries(11'd1024);
    pending_reqs.push_back(make_req(REQ_ACCESS, 262143, 1048575, 1, 1023));
    pending_reqs.push_back(make_req(REQ_ACCESS, 262143, 1048575, 0, 0));
    pending_reqs.push_back(make_req(REQ_ACCESS, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_PIN, 5, 3, 0, 1023));
    pending_reqs.push_back(make_req(REQ_ACCESS, 5, 3, 1, 0));
    pending_reqs.push_back(make_req(REQ_DONE, 0, 0, 0, 1023));
    pending_reqs.push_back(make_req(REQ_ACCESS, 0, 7, 1, 0));
    pending_reqs.push_back(make_req(REQ_RELEASE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_RELEASE, 262143, 0, 0, 0));

    // Two entries: all pinned, slot out of range, dirty victim left busy.
    set_entries(11'd2);
    pending_reqs.push_back(make_req(REQ_PIN, 7, 1, 0, 0));
    pending_reqs.push_back(make_req(REQ_PIN, 8, 2, 0, 1));
    pending_reqs.push_back(make_req(REQ_ACCESS, 1, 1, 0, 0));
    pending_reqs.push_back(make_req(REQ_PIN, 9, 9, 0, 5));
    pending_reqs.push_back(make_req(REQ_DONE, 0, 0, 0, 2));
    pending_reqs.push_back(make_req(REQ_PIN, 0, 4, 0, 0));
    pending_reqs.push_back(make_req(REQ_ACCESS, 2, 4, 1, 0));
    pending_reqs.push_back(make_req(REQ_ACCESS, 3, 5, 1, 0));
    pending_reqs.push_back(make_req(REQ_ACCESS, 4, 6, 0, 0));
    pending_reqs.push_back(make_req(REQ_DONE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_DONE, 0, 0, 0, 1));
    pending_reqs.push_back(make_req(REQ_ACCESS, 4, 6, 0, 0));
    pending_reqs.push_back(make_req(REQ_RELEASE, 8, 0, 0, 0));

    random_phase(11'd1, 30);
    random_phase(11'd0, 20);
    random_phase(11'd8, 60);
    random_phase(11'd3, 50);
    random_phase(11'd2047, 16);
    random_phase(11'd16, 60);
    random_phase(11'd1024, 14);
    random_phase(11'd64, 18);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("clock_page_frame_table: match");
    end else begin
      $display("clock_page_frame_table: mismatch");
    end
    $finish;
  end
endmodule
